[rtl/core/lasp_pkg.sv]
// Package for the ASCII scan telegram parser: framing characters, default
// register values, result and error codes, parse phases and small decoders.
// Depends on nothing; used by lidar_ascii_scan_telegram_parser.
package lasp_pkg;

  localparam logic [7:0] STX_CHAR = 8'h02;
  localparam logic [7:0] ETX_CHAR = 8'h03;

  localparam int unsigned VALUE_BITS_DEFAULT = 32;

  localparam logic [15:0] MAX_FRAME_LENGTH_RESET   = 16'd10000;
  localparam logic [3:0]  COUNT_TOKEN_OFFSET_RESET = 4'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_FRAME_LENGTH   = 2'd0;
  localparam logic [1:0] REG_COUNT_TOKEN_OFFSET = 2'd1;

  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_MARKER = 2'd1;
  localparam logic [1:0] ERR_SHORT     = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd3;

  localparam logic [2:0] MARKER_LEN    = 3'd5;
  localparam logic [3:0] TOKEN_SAT     = 4'hF;
  localparam logic [15:0] COUNT_SAT    = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_AWAIT  = 4'b0010,
    PH_READ   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] distance;
    logic [15:0] index;
    logic        last;
    logic [1:0]  err;
  } result_t;

  function automatic logic [7:0] marker_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h44; // D
      3'd1:    c = 8'h49; // I
      3'd2:    c = 8'h53; // S
      3'd3:    c = 8'h54; // T
      3'd4:    c = 8'h31; // 1
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [3:0] d;
    d = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = 4'(b - 8'h57);
    end
    return d;
  endfunction

endpackage

[rtl/core/lidar_ascii_scan_telegram_parser.sv]
// Streaming parser for ASCII scan telegrams: one byte in, at most one reading
// or frame error out. Depends on lasp_pkg.
// The result of a byte is registered in the output register, or in the skid
// register if that is full and stalled. Throughput: one byte per cycle unless
// in_stall, which rises only when output and skid register both hold items.
// Reset (rst, synchronous): waiting for STX, registers at their defaults.
module lidar_ascii_scan_telegram_parser #(
  parameter int unsigned VALUE_BITS = lasp_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [31:0] distance,
  output logic [15:0] reading_index,
  output logic        last_reading,
  output logic [1:0]  error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lasp_pkg::*;

  // Configuration
  logic [15:0] max_frame_length;
  logic [3:0]  count_token_offset;

  // Parse state
  logic                  in_frame, in_frame_next;
  logic [15:0]           frame_length, frame_length_next;
  logic [VALUE_BITS-1:0] token_value, token_value_next;
  logic                  token_active, token_active_next;
  logic [2:0]            match_progress, match_progress_next;
  logic                  match_failed, match_failed_next;
  phase_t                parse_phase, parse_phase_next;
  logic [3:0]            tokens_after_marker, tokens_after_marker_next;
  logic [15:0]           readings_left, readings_left_next;
  logic [15:0]           next_index, next_index_next;

  // Token close results
  phase_t      ct_phase;
  logic [3:0]  ct_tam;
  logic [15:0] ct_left;
  logic [15:0] ct_index;
  logic        ct_emit;
  result_t     ct_res;
  logic [63:0] tok_wide;
  logic [15:0] count_sat;
  logic [3:0]  tam_inc;

  // Token extension
  logic [VALUE_BITS-1:0] tok_base;
  logic [2:0]            mp_base;
  logic                  mf_base;

  result_t res;
  logic    res_valid;
  logic    accept;

  result_t out_item, skid_item;
  logic    skid_valid;
  logic    take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign take      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length   <= MAX_FRAME_LENGTH_RESET;
      count_token_offset <= COUNT_TOKEN_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_FRAME_LENGTH:   max_frame_length <= cfg_data;
        REG_COUNT_TOKEN_OFFSET: count_token_offset <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Completion of the open token, taken from the current state
  always_comb begin
    tok_wide  = 64'(token_value);
    count_sat = (|tok_wide[63:16]) ? COUNT_SAT : tok_wide[15:0];
    tam_inc   = (tokens_after_marker != TOKEN_SAT) ? tokens_after_marker + 4'd1
                                                   : tokens_after_marker;
    ct_phase = parse_phase;
    ct_tam   = tokens_after_marker;
    ct_left  = readings_left;
    ct_index = next_index;
    ct_emit  = 1'b0;
    ct_res   = '0;
    if (token_active) begin
      case (parse_phase)
        PH_SEARCH: begin
          if (!match_failed && match_progress == MARKER_LEN) begin
            ct_phase = PH_AWAIT;
            ct_tam   = 4'd0;
          end
        end
        PH_AWAIT: begin
          ct_tam = tam_inc;
          if (tam_inc == count_token_offset) begin
            ct_left  = count_sat;
            ct_index = 16'd0;
            ct_phase = (count_sat != 16'd0) ? PH_READ : PH_DONE;
          end
        end
        PH_READ: begin
          ct_emit         = 1'b1;
          ct_res.kind     = KIND_READING;
          ct_res.distance = tok_wide[31:0];
          ct_res.index    = next_index;
          ct_res.last     = (readings_left == 16'd1);
          ct_res.err      = ERR_NONE;
          ct_left         = readings_left - 16'd1;
          ct_index        = next_index + 16'd1;
          if (readings_left == 16'd1) begin
            ct_phase = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_next            = in_frame;
    frame_length_next        = frame_length;
    token_value_next         = token_value;
    token_active_next        = token_active;
    match_progress_next      = match_progress;
    match_failed_next        = match_failed;
    parse_phase_next         = parse_phase;
    tokens_after_marker_next = tokens_after_marker;
    readings_left_next       = readings_left;
    next_index_next          = next_index;
    res_valid                = 1'b0;
    res                      = '0;

    tok_base = token_active ? token_value : '0;
    mp_base  = token_active ? match_progress : 3'd0;
    mf_base  = token_active ? match_failed : 1'b0;

    if (!in_frame) begin
      if (rx_byte == STX_CHAR) begin
        in_frame_next            = 1'b1;
        frame_length_next        = 16'd0;
        token_value_next         = '0;
        token_active_next        = 1'b0;
        match_progress_next      = 3'd0;
        match_failed_next        = 1'b0;
        parse_phase_next         = PH_SEARCH;
        tokens_after_marker_next = 4'd0;
        readings_left_next       = 16'd0;
        next_index_next          = 16'd0;
      end
    end else if (rx_byte == ETX_CHAR) begin
      // Close any open token, then judge the frame
      in_frame_next            = 1'b0;
      token_active_next        = 1'b0;
      parse_phase_next         = ct_phase;
      tokens_after_marker_next = ct_tam;
      readings_left_next       = ct_left;
      next_index_next          = ct_index;
      if (ct_phase == PH_DONE) begin
        res_valid = ct_emit;
        res       = ct_res;
      end else begin
        res_valid = 1'b1;
        res.kind  = KIND_ERROR;
        res.err   = (ct_phase == PH_SEARCH) ? ERR_NO_MARKER : ERR_SHORT;
      end
    end else if (frame_length >= max_frame_length) begin
      in_frame_next = 1'b0;
      res_valid     = 1'b1;
      res.kind      = KIND_ERROR;
      res.err       = ERR_TOO_LONG;
    end else begin
      frame_length_next = frame_length + 16'd1;
      if (is_space(rx_byte)) begin
        token_active_next        = 1'b0;
        parse_phase_next         = ct_phase;
        tokens_after_marker_next = ct_tam;
        readings_left_next       = ct_left;
        next_index_next          = ct_index;
        res_valid                = ct_emit;
        res                      = ct_res;
      end else begin
        token_active_next   = 1'b1;
        token_value_next    = {tok_base[VALUE_BITS-5:0], hex_digit(rx_byte)};
        match_progress_next = mp_base;
        match_failed_next   = mf_base;
        if (!mf_base) begin
          if (mp_base < MARKER_LEN && rx_byte == marker_char(mp_base)) begin
            match_progress_next = mp_base + 3'd1;
          end else begin
            match_failed_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame            <= 1'b0;
      frame_length        <= 16'd0;
      token_value         <= '0;
      token_active        <= 1'b0;
      match_progress      <= 3'd0;
      match_failed        <= 1'b0;
      parse_phase         <= PH_SEARCH;
      tokens_after_marker <= 4'd0;
      readings_left       <= 16'd0;
      next_index          <= 16'd0;
    end else if (accept) begin
      in_frame            <= in_frame_next;
      frame_length        <= frame_length_next;
      token_value         <= token_value_next;
      token_active        <= token_active_next;
      match_progress      <= match_progress_next;
      match_failed        <= match_failed_next;
      parse_phase         <= parse_phase_next;
      tokens_after_marker <= tokens_after_marker_next;
      readings_left       <= readings_left_next;
      next_index          <= next_index_next;
    end
  end

  // Output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (take || !out_valid) begin
      out_valid <= accept && res_valid;
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_item <= skid_item;
      end
    end else if (take || !out_valid) begin
      out_item <= res;
    end else if (accept && res_valid) begin
      skid_item <= res;
    end
  end

  assign result_kind   = out_item.kind;
  assign distance      = out_item.distance;
  assign reading_index = out_item.index;
  assign last_reading  = out_item.last;
  assign error_code    = out_item.err;

endmodule

[tb/tb.sv]
// Testbench for lidar_ascii_scan_telegram_parser: byte stream in, readings and frame errors out.
// A scoreboard class predicts each result as bytes are taken and checks what the block returns.
// Depends on lasp_pkg and the parser RTL only.
module tb;
  import lasp_pkg::*;

  class scan_scoreboard;
    bit [15:0] max_len;
    bit [3:0]  count_offset;
    bit        framing;
    bit [15:0] frame_len;
    bit [31:0] tok_val;
    bit        tok_open;
    bit [2:0]  matched;
    bit        mismatch;
    phase_t    scan_phase;
    bit [3:0]  after_marker;
    bit [15:0] readings_due;
    bit [15:0] reading_no;
    string     marker_txt;
    result_t   expected_q[$];
    int        errors;

    function new();
      marker_txt   = "DIST1";
      max_len      = MAX_FRAME_LENGTH_RESET;
      count_offset = COUNT_TOKEN_OFFSET_RESET;
      errors       = 0;
      open_frame();
      framing      = 1'b0;
    endfunction

    function void open_frame();
      framing      = 1'b1;
      frame_len    = '0;
      tok_val      = '0;
      tok_open     = 1'b0;
      matched      = '0;
      mismatch     = 1'b0;
      scan_phase   = PH_SEARCH;
      after_marker = '0;
      readings_due = '0;
      reading_no   = '0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [15:0] data);
      if (idx == REG_MAX_FRAME_LENGTH) begin
        max_len = data;
      end else if (idx == REG_COUNT_TOKEN_OFFSET) begin
        count_offset = data[3:0];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void expect_item(result_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function bit is_blank(bit [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function bit [3:0] digit_value(bit [7:0] b);
      if (b >= "0" && b <= "9") return 4'(b - "0");
      if (b >= "A" && b <= "F") return 4'(b - "A" + 10);
      if (b >= "a" && b <= "f") return 4'(b - "a" + 10);
      return 4'd0;
    endfunction

    function void push_error(bit [1:0] code);
      result_t r;
      r      = '0;
      r.kind = KIND_ERROR;
      r.err  = code;
      expect_item(r);
    endfunction

    // Close the open token; returns 1 when it yields a reading in r.
    function bit finish_token(output result_t r);
      bit [31:0] v;
      r = '0;
      if (!tok_open) return 1'b0;
      tok_open = 1'b0;
      v = tok_val;
      case (scan_phase)
        PH_SEARCH: begin
          if (!mismatch && matched == MARKER_LEN) begin
            scan_phase   = PH_AWAIT;
            after_marker = '0;
          end
        end
        PH_AWAIT: begin
          if (after_marker != TOKEN_SAT) after_marker++;
          if (after_marker == count_offset) begin
            readings_due = (v > 32'hFFFF) ? COUNT_SAT : v[15:0];
            reading_no   = '0;
            scan_phase   = (readings_due != 0) ? PH_READ : PH_DONE;
          end
        end
        PH_READ: begin
          r.kind     = KIND_READING;
          r.distance = v;
          r.index    = reading_no;
          r.last     = (readings_due == 16'd1);
          r.err      = ERR_NONE;
          readings_due--;
          reading_no++;
          if (readings_due == 0) scan_phase = PH_DONE;
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_byte(bit [7:0] b);
      result_t r;
      bit      got;
      if (!framing) begin
        if (b == STX_CHAR) open_frame();
        return;
      end
      if (b == ETX_CHAR) begin
        got     = finish_token(r);
        framing = 1'b0;
        if (scan_phase == PH_DONE) begin
          if (got) expect_item(r);
        end else begin
          // an unfinished scan drops any reading from the closing token
          push_error(scan_phase == PH_SEARCH ? ERR_NO_MARKER : ERR_SHORT);
        end
        return;
      end
      if (frame_len >= max_len) begin
        framing = 1'b0;
        push_error(ERR_TOO_LONG);
        return;
      end
      frame_len++;
      if (is_blank(b)) begin
        if (finish_token(r)) expect_item(r);
        return;
      end
      if (!tok_open) begin
        tok_open = 1'b1;
        tok_val  = '0;
        matched  = '0;
        mismatch = 1'b0;
      end
      tok_val = {tok_val[27:0], digit_value(b)};
      if (!mismatch) begin
        if (matched < MARKER_LEN && b == marker_txt[matched]) matched++;
        else mismatch = 1'b1;
      end
    endfunction

    function void compare_field(string name, bit [31:0] exp, bit [31:0] act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d dist %0h",
                 $time, got.kind, got.distance);
        $display("%0t: unexpected result, actual idx %0d last %0d err %0d",
                 $time, got.index, got.last, got.err);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("result_kind", 32'(exp.kind), 32'(got.kind));
      compare_field("distance", exp.distance, got.distance);
      compare_field("reading_index", 32'(exp.index), 32'(got.index));
      compare_field("last_reading", 32'(exp.last), 32'(got.last));
      compare_field("error_code", 32'(exp.err), 32'(got.err));
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [31:0] distance;
  logic [15:0] reading_index;
  logic        last_reading;
  logic [1:0]  error_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  scan_scoreboard sb;
  bit [7:0]  frame_q[$];
  bit        quiet;
  bit        hold_req;
  int        bytes_sent;
  bit [15:0] cur_max;
  bit [3:0]  cur_offset;

  lidar_ascii_scan_telegram_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .distance      (distance),
    .reading_index (reading_index),
    .last_reading  (last_reading),
    .error_code    (error_code),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- telegram building ----

  function automatic void put_byte(bit [7:0] c);
    frame_q.insert(frame_q.size(), c);
  endfunction

  function automatic bit [7:0] hex_char(bit [3:0] d, bit lower);
    if (d < 10) return 8'(8'h30 + d);
    return 8'((lower ? 8'h57 : 8'h37) + d);
  endfunction

  function automatic void put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_sep();
    int n, k;
    n = ($urandom_range(0, 4) == 0) ? 2 : 1;
    repeat (n) begin
      k = $urandom_range(0, 9);
      put_byte(k < 5 ? 8'h20 : 8'(8'h04 + k));
    end
  endfunction

  function automatic void put_count(bit [31:0] v);
    int n, i;
    bit lower;
    lower = $urandom_range(0, 1);
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    n += $urandom_range(0, 1);
    for (i = n - 1; i >= 0; i--) put_byte(hex_char(4'(v >> (4 * i)), lower));
  endfunction

  // Mostly hex digits in either case, some letters beyond F, now and then any non-blank byte.
  function automatic void put_token(int max_chars);
    int n, i, k;
    bit [7:0] c;
    n = $urandom_range(1, max_chars);
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 15) begin
        c = hex_char(4'($urandom_range(0, 15)), k >= 10);
      end else if (k < 19) begin
        c = 8'((k == 15 ? "g" : "G") + $urandom_range(0, 19));
      end else begin
        c = 8'($urandom_range(8'h0E, 8'hFF));
        if (c == 8'h20) c = STX_CHAR;
      end
      put_byte(c);
    end
  endfunction

  function automatic void build_scan(bit pressure);
    int i, n, fill, given;
    bit [31:0] cnt;
    bit [7:0]  c;
    n = pressure ? 0 : $urandom_range(0, 2);
    for (i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == STX_CHAR) c = 8'h00;
      put_byte(c);
    end
    put_byte(STX_CHAR);
    n = pressure ? 0 : $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      put_token(8);
      put_sep();
    end
    put_text("DIST1");
    put_sep();
    fill = (cur_offset == 0) ? $urandom_range(0, 3) : cur_offset - 1;
    for (i = 0; i < fill; i++) begin
      put_token(8);
      put_sep();
    end
    if (pressure) begin
      cnt = 24;
    end else begin
      case ($urandom_range(0, 9))
        0:       cnt = 0;
        1:       cnt = 32'($urandom_range(32'h10000, 32'hFFFFFFFF));
        default: cnt = 32'($urandom_range(1, 6));
      endcase
    end
    put_count(cnt);
    given = int'(cnt);
    if (cnt > 64) begin
      given = $urandom_range(0, 3);
    end else if (!pressure) begin
      case ($urandom_range(0, 9))
        0:       given = (cnt == 0) ? 0 : $urandom_range(0, int'(cnt) - 1);
        1:       given = int'(cnt) + $urandom_range(1, 3);
        default: ;
      endcase
    end
    for (i = 0; i < given; i++) begin
      put_sep();
      case ($urandom_range(0, 19))
        0:       put_text("FFFFFFFF");
        1:       put_text("0");
        2:       put_token(12);
        default: put_token(8);
      endcase
    end
    if ($urandom_range(0, 1)) put_sep();
    put_byte(ETX_CHAR);
  endfunction

  // Near misses of the marker, the marker itself, random tokens, or no tokens at all.
  function automatic void build_broken();
    int i, n;
    put_byte(STX_CHAR);
    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 6))
        0:       put_text("DIST");
        1:       put_text("DIST2");
        2:       put_text("DIST11");
        3:       put_text("dist1");
        4:       put_text("XDIST1");
        5:       put_text("DIST1");
        default: put_token(6);
      endcase
      put_sep();
    end
    if ($urandom_range(0, 1)) put_token(4);
    put_byte(ETX_CHAR);
  endfunction

  function automatic void build_junk();
    int n;
    put_byte(STX_CHAR);
    n = $urandom_range(3, 25);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
    put_byte(ETX_CHAR);
  endfunction

  // ---- drivers ----

  task automatic send_byte(input bit [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  // Hold input until every expected result is back, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bit [1:0] idx, input bit [15:0] data, input bit lower);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (lower) cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic set_regs(input bit [15:0] max_len, input bit [3:0] offset);
    write_reg(REG_MAX_FRAME_LENGTH, max_len, 1'b0);
    write_reg(REG_COUNT_TOKEN_OFFSET, {12'($urandom), offset}, 1'b1);
    cur_max    = max_len;
    cur_offset = offset;
  endtask

  // ---- result side: stall, accept, check ----
  initial begin
    int      n;
    result_t seen;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = quiet ? 0 : $urandom_range(0, 8);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      seen.kind     = result_kind;
      seen.distance = distance;
      seen.index    = reading_index;
      seen.last     = last_reading;
      seen.err      = error_code;
      sb.check_result(seen);
    end
  end

  // ---- watchdog: stop when nothing moves for too long ----
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---- stimulus ----
  initial begin
    int p, k, target;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    rx_byte    <= 8'h00;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_MAX_FRAME_LENGTH;
    cfg_data   <= 16'h0000;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    cur_max    = MAX_FRAME_LENGTH_RESET;
    cur_offset = COUNT_TOKEN_OFFSET_RESET;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: full scan ending on an open token, then a frame with no marker.
    put_byte(STX_CHAR);
    put_text("DIST1 a b c d 2 FFFFFFFF 0");
    put_byte(ETX_CHAR);
    put_byte(STX_CHAR);
    put_text("x");
    put_byte(ETX_CHAR);
    send_frame();

    target = bytes_sent;
    for (p = 0; p < 10; p++) begin
      drain();
      case (p)
        0:       set_regs(16'hFFFF, 4'd1);
        1:       set_regs(MAX_FRAME_LENGTH_RESET, 4'd15);
        2:       set_regs(16'($urandom_range(6, 40)), 4'($urandom_range(1, 4)));
        3:       set_regs(16'd0, 4'd0);
        4:       set_regs(16'd1, 4'd2);
        5:       set_regs(MAX_FRAME_LENGTH_RESET, 4'd1);
        6:       set_regs(16'($urandom_range(100, 2000)), 4'($urandom_range(1, 15)));
        default: set_regs($urandom_range(0, 1) ? MAX_FRAME_LENGTH_RESET
                                               : 16'($urandom_range(20, 500)),
                          4'($urandom_range(1, 8)));
      endcase
      if (p == 5) begin
        // Back-pressure: receiver holds off while bytes keep coming at full rate.
        quiet    = 1'b1;
        hold_req = 1'b1;
        build_scan(1'b1);
        send_frame();
        quiet = 1'b0;
      end else begin
        quiet  = ($urandom_range(0, 3) == 0);
        target += (p == 3 || p == 4) ? 40 : 130;
        while (bytes_sent < target) begin
          k = $urandom_range(0, 99);
          if (k < 70) build_scan(1'b0);
          else if (k < 85) build_broken();
          else build_junk();
          send_frame();
        end
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
